### rtl/qtbn_pkg.sv
// Shared types and constants for the QTangent to TBN matrix unit.
// Used by the front end, the request queue and the divider back end.
`default_nettype none
package qtbn_pkg;
    localparam int LANES = 9;      // matrix entries per request
    localparam int NW    = 53;     // signed scaled numerator width
    localparam int DW    = 35;     // doubled denominator width
    localparam int RW    = 35;     // partial remainder width
    localparam int QW    = 15;     // quotient magnitude width
    localparam int OW    = 16;     // output entry width

    localparam logic [33:0] MIN_SUMSQ = 34'd43;
    localparam logic [33:0] FULL_SQ   = 34'd4294836225;
    localparam logic signed [16:0] ONE_POS = 17'sd16384;
    localparam logic signed [16:0] ONE_NEG = -17'sd16384;

    // One request as it leaves the front end: nine numerators and the divisor.
    typedef struct packed {
        logic [LANES-1:0][NW-1:0] num;
        logic [DW-1:0]            dd;
    } qtbn_item_t;
endpackage
`default_nettype wire

### rtl/qtbn_front.sv
// Front end: decodes components, forms products, sums and scaled numerators.
// Depends on qtbn_pkg.
`default_nettype none
module qtbn_front import qtbn_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [63:0] in_data,
    output logic             push,
    input  wire logic        q_full,
    output qtbn_item_t       push_item
);
    logic v1_reg, v2_reg, v3_reg;
    logic en;

    logic signed [16:0] cx, cy, cz, cw;
    logic signed [33:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [33:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    logic [33:0]        s_reg;
    logic signed [35:0] syz_reg, sxz_reg, sxy_reg;
    logic signed [35:0] a1_reg, a2_reg, a3_reg, a5_reg, a6_reg, a7_reg;
    qtbn_item_t         item_reg;

    logic [33:0]        d;
    logic signed [36:0] dn;
    logic signed [36:0] nval [LANES];

    function automatic logic signed [16:0] comp(input logic [15:0] q);
        logic signed [17:0] t;
        t = $signed({1'b0, q, 1'b0}) - 18'sd65535;
        return t[16:0];
    endfunction

    assign en        = !v3_reg || !q_full;
    assign in_ready  = en;
    assign push      = v3_reg && !q_full;
    assign push_item = item_reg;

    assign cx = comp(in_data[15:0]);
    assign cy = comp(in_data[31:16]);
    assign cz = comp(in_data[47:32]);
    assign cw = comp(in_data[63:48]);

    always_comb begin
        d  = (s_reg >= MIN_SUMSQ) ? s_reg : FULL_SQ;
        dn = $signed({3'b000, d});
        nval[0] = dn - (37'(syz_reg) <<< 1);
        nval[1] = 37'(a1_reg) <<< 1;
        nval[2] = 37'(a2_reg) <<< 1;
        nval[3] = 37'(a3_reg) <<< 1;
        nval[4] = dn - (37'(sxz_reg) <<< 1);
        nval[5] = 37'(a5_reg) <<< 1;
        nval[6] = 37'(a6_reg) <<< 1;
        nval[7] = 37'(a7_reg) <<< 1;
        nval[8] = dn - (37'(sxy_reg) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= cx * cx;
            yy_reg <= cy * cy;
            zz_reg <= cz * cz;
            ww_reg <= cw * cw;
            xy_reg <= cx * cy;
            xz_reg <= cx * cz;
            yz_reg <= cy * cz;
            wx_reg <= cw * cx;
            wy_reg <= cw * cy;
            wz_reg <= cw * cz;

            s_reg   <= 34'(xx_reg) + 34'(yy_reg) + 34'(zz_reg) + 34'(ww_reg);
            syz_reg <= 36'(yy_reg) + 36'(zz_reg);
            sxz_reg <= 36'(xx_reg) + 36'(zz_reg);
            sxy_reg <= 36'(xx_reg) + 36'(yy_reg);
            a1_reg  <= 36'(xy_reg) + 36'(wz_reg);
            a2_reg  <= 36'(xz_reg) - 36'(wy_reg);
            a3_reg  <= 36'(xy_reg) - 36'(wz_reg);
            a5_reg  <= 36'(yz_reg) + 36'(wx_reg);
            a6_reg  <= 36'(xz_reg) + 36'(wy_reg);
            a7_reg  <= 36'(yz_reg) - 36'(wx_reg);

            // Scale by 32768 and add D so that the divide by 2D rounds to nearest.
            for (int l = 0; l < LANES; l++) begin
                item_reg.num[l] <= (NW'(nval[l]) <<< 15) + NW'({1'b0, d});
            end
            item_reg.dd <= {d, 1'b0};
        end
    end
endmodule
`default_nettype wire

### rtl/qtbn_queue.sv
// Short request queue between the front end and the divider back end.
// Depends on qtbn_pkg.
`default_nettype none
module qtbn_queue import qtbn_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  qtbn_item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       empty,
    output qtbn_item_t pop_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    qtbn_item_t      mem [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) begin
                wr_reg <= (wr_reg == LAST) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_reg <= (rd_reg == LAST) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

### rtl/qtbn_divider.sv
// Back end: nine-lane pipelined restoring divider, one quotient bit per stage,
// followed by sign, clamp and the output register. Depends on qtbn_pkg.
`default_nettype none
module qtbn_divider import qtbn_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         q_empty,
    output logic              pop,
    input  qtbn_item_t        pop_item,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [143:0]      out_data
);
    localparam int ST = QW + 1;

    logic                 vld_reg [ST];
    logic [DW-1:0]        dd_reg  [ST];
    logic [RW-1:0]        rem_reg [ST][LANES];
    logic [QW-1:0]        lo_reg  [ST][LANES];
    logic [QW-1:0]        quo_reg [ST][LANES];
    logic                 neg_reg [ST][LANES];
    logic                 ov_reg;
    logic [143:0]         od_reg;
    logic                 en;

    logic [NW-1:0]        mag [LANES];
    logic [RW-1:0]        rem_n [ST][LANES];
    logic                 qb_n  [ST][LANES];
    logic signed [16:0]   sval [LANES];
    logic signed [16:0]   cval [LANES];

    assign en        = !ov_reg || out_ready;
    assign pop       = en && !q_empty;
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            // A negative numerator needs a ceiling to give floor of the signed quotient.
            if (pop_item.num[l][NW-1]) begin
                mag[l] = -pop_item.num[l] + NW'(pop_item.dd) - NW'(1);
            end else begin
                mag[l] = pop_item.num[l];
            end
        end
        for (int i = 0; i < ST; i++) begin
            for (int l = 0; l < LANES; l++) begin
                rem_n[i][l] = '0;
                qb_n[i][l]  = 1'b0;
            end
        end
        for (int i = 1; i < ST; i++) begin
            for (int l = 0; l < LANES; l++) begin
                logic [RW:0] sh;
                sh = {rem_reg[i-1][l], lo_reg[i-1][l][QW-i]};
                if (sh >= {1'b0, dd_reg[i-1]}) begin
                    qb_n[i][l]  = 1'b1;
                    rem_n[i][l] = RW'(sh - {1'b0, dd_reg[i-1]});
                end else begin
                    rem_n[i][l] = sh[RW-1:0];
                end
            end
        end
        for (int l = 0; l < LANES; l++) begin
            sval[l] = neg_reg[ST-1][l] ? -$signed({2'b00, quo_reg[ST-1][l]})
                                       :  $signed({2'b00, quo_reg[ST-1][l]});
            if (sval[l] > ONE_POS) begin
                cval[l] = ONE_POS;
            end else if (sval[l] < ONE_NEG) begin
                cval[l] = ONE_NEG;
            end else begin
                cval[l] = sval[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ST; i++) begin
                vld_reg[i] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= !q_empty;
            for (int i = 1; i < ST; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            ov_reg <= vld_reg[ST-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dd_reg[0] <= pop_item.dd;
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= mag[l][RW+QW-1:QW];
                lo_reg[0][l]  <= mag[l][QW-1:0];
                quo_reg[0][l] <= '0;
                neg_reg[0][l] <= pop_item.num[l][NW-1];
            end
            for (int i = 1; i < ST; i++) begin
                dd_reg[i] <= dd_reg[i-1];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[i][l] <= rem_n[i][l];
                    lo_reg[i][l]  <= lo_reg[i-1][l];
                    quo_reg[i][l] <= {quo_reg[i-1][l][QW-2:0], qb_n[i][l]};
                    neg_reg[i][l] <= neg_reg[i-1][l];
                end
            end
            for (int l = 0; l < LANES; l++) begin
                od_reg[l*OW +: OW] <= cval[l][OW-1:0];
            end
        end
    end
endmodule
`default_nettype wire

### rtl/qtangent_to_tbn_matrix_unit.sv
// Top level of the QTangent to TBN matrix unit: front end, request queue, divider.
// Depends on qtbn_pkg, qtbn_front, qtbn_queue and qtbn_divider.
//
//   Channel | Ports                      | Payload
//   input   | s_tvalid s_tready s_tdata  | quat_x, quat_y, quat_z, quat_w
//   result  | m_tvalid m_tready m_tdata  | tan, bin, nrm rows (x, y, z each)
//
// One request is accepted per cycle unless a full queue stalls the front end;
// a request passes three front-end stages, the request queue, sixteen divider
// stages (a load stage and fifteen quotient-bit stages) and the output register.
// Reset clears all valid flags and the queue pointers.
// A stalled result holds the divider; the queue then absorbs the front end.
`default_nettype none
module qtangent_to_tbn_matrix_unit import qtbn_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // quat_x, quat_y, quat_z, quat_w
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [143:0]      m_tdata    // tan_x..z, bin_x..z, nrm_x..z
);
    qtbn_item_t push_item, pop_item;
    logic       push, q_full, pop, q_empty;

    qtbn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .push      (push),
        .q_full    (q_full),
        .push_item (push_item)
    );

    qtbn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    qtbn_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .pop       (pop),
        .pop_item  (pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );
endmodule
`default_nettype wire

### sim/tb_top.sv
// Testbench for the QTangent to TBN matrix unit: streams quaternions in and
// checks every tangent-frame result against a predictor kept in this file.
// Depends on qtbn_pkg and qtangent_to_tbn_matrix_unit.
module tb_top;
    import qtbn_pkg::*;

    typedef struct packed {
        logic [15:0] w, z, y, x;
    } quat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;

    logic [143:0] frame_q[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           items_sent = 0;
    int           cycles = 0;
    int           hold_cycles = 0;
    bit           send_calm = 1'b0;
    bit           recv_calm = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    qtangent_to_tbn_matrix_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Rounded, clamped 16384*num/den with ties going upward.
    function automatic logic [15:0] scaled_entry(longint num, longint den);
        longint n, d, q;
        n = num * 32768 + den;
        d = 2 * den;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        if (q > 16384) q = 16384;
        if (q < -16384) q = -16384;
        return q[15:0];
    endfunction

    function automatic logic [143:0] tbn_frame(quat_t qv);
        longint x, y, z, w, s, d;
        logic [143:0] r;
        x = 2 * longint'(qv.x) - 65535;
        y = 2 * longint'(qv.y) - 65535;
        z = 2 * longint'(qv.z) - 65535;
        w = 2 * longint'(qv.w) - 65535;
        s = x*x + y*y + z*z + w*w;
        d = (s >= 43) ? s : 64'd4294836225;
        r[15:0]    = scaled_entry(d - 2*(y*y + z*z), d);
        r[31:16]   = scaled_entry(2*(x*y + w*z), d);
        r[47:32]   = scaled_entry(2*(x*z - w*y), d);
        r[63:48]   = scaled_entry(2*(x*y - w*z), d);
        r[79:64]   = scaled_entry(d - 2*(x*x + z*z), d);
        r[95:80]   = scaled_entry(2*(y*z + w*x), d);
        r[111:96]  = scaled_entry(2*(x*z + w*y), d);
        r[127:112] = scaled_entry(2*(y*z - w*x), d);
        r[143:128] = scaled_entry(d - 2*(x*x + y*y), d);
        return r;
    endfunction

    // Receiver: random back-pressure, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= recv_calm || ($urandom_range(99) >= 36);
        end
    end

    always @(posedge aclk) begin
        logic [143:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (frame_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = frame_q.pop_front();
                for (int i = 0; i < 9; i++) begin
                    if (m_tdata[16*i +: 16] !== want[16*i +: 16]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("entry %0d: expected %h got %h", i,
                                     want[16*i +: 16], m_tdata[16*i +: 16]);
                    end
                end
            end
        end
    end

    task automatic send_quat(quat_t qv);
        while (!send_calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= qv;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_q = {frame_q, tbn_frame(qv)};
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_extremes();
        logic [15:0] vals[4] = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
        for (int i = 0; i < 4; i++)
            send_quat('{w: vals[i], z: vals[i], y: vals[i], x: vals[i]});
        // Near axis-aligned unit quaternions, then two with equal-magnitude components.
        send_quat('{w: 16'hFFFF, z: 16'h7FFF, y: 16'h7FFF, x: 16'h7FFF});
        send_quat('{w: 16'h7FFF, z: 16'h7FFF, y: 16'h7FFF, x: 16'hFFFF});
        send_quat('{w: 16'h7FFF, z: 16'h7FFF, y: 16'h0000, x: 16'h7FFF});
        send_quat('{w: 16'h7FFF, z: 16'hFFFF, y: 16'h8000, x: 16'h8000});
        send_quat('{w: 16'h0000, z: 16'hFFFF, y: 16'h0000, x: 16'hFFFF});
        send_quat('{w: 16'hAAAA, z: 16'h5555, y: 16'hAAAA, x: 16'h5555});
    endtask

    task automatic test_near_zero();
        // Components of 32767 or 32768 give c = -1 or +1, so S = 4 < 43.
        send_quat('{w: 16'h8000, z: 16'h7FFF, y: 16'h8000, x: 16'h7FFF});
        send_quat('{w: 16'h7FFF, z: 16'h7FFF, y: 16'h7FFF, x: 16'h8000});
        // c = 3,3,3,1 gives S = 28; c = 3,-3,3,3 gives S = 36.
        send_quat('{w: 16'h8000, z: 16'h8001, y: 16'h8001, x: 16'h8001});
        send_quat('{w: 16'h8001, z: 16'h8001, y: 16'h7FFE, x: 16'h8001});
        // c = 5,3,3,1 gives S = 44, just above the threshold; -5,3,-3,-1 as well.
        send_quat('{w: 16'h8000, z: 16'h8001, y: 16'h8001, x: 16'h8002});
        send_quat('{w: 16'h7FFF, z: 16'h7FFE, y: 16'h8001, x: 16'h7FFD});
        // c = 7,1,1,1 gives S = 52.
        send_quat('{w: 16'h8000, z: 16'h8000, y: 16'h8000, x: 16'h8003});
    endtask

    function automatic quat_t random_quat();
        quat_t qv;
        case ($urandom_range(9))
            0: qv = {4{16'h7FFF + 16'($urandom_range(5)) - 16'd2}};
            1: for (int i = 0; i < 4; i++)
                   qv[16*i +: 16] = 16'h7FFE + 16'($urandom_range(4));
            2: qv = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom),
                     16'($urandom), 16'($urandom)};
            default: qv = {$urandom, $urandom};
        endcase
        return qv;
    endfunction

    task automatic test_random_stream(int count);
        for (int i = 0; i < count; i++) send_quat(random_quat());
    endtask

    task automatic test_back_pressure();
        // The sender keeps offering while the receiver is held, so the queue fills.
        hold_cycles = 200;
        send_calm = 1'b1;
        test_random_stream(40);
        send_calm = 1'b0;
        drain_results();
        // Full rate in both directions, then a pause until the pipe is empty.
        send_calm = 1'b1;
        recv_calm = 1'b1;
        test_random_stream(80);
        drain_results();
        send_calm = 1'b0;
        recv_calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_extremes();
        test_near_zero();
        test_random_stream(150);
        test_back_pressure();
        test_random_stream(130);
        drain_results();
        repeat (40) @(posedge aclk);
        $display("sent %0d quaternions, checked %0d frames, including near-zero",
                 items_sent, results_seen);
        $display("inputs, full-scale components and a long output stall.");
        if (mismatches == 0 && frame_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

### sim.f
rtl/qtbn_pkg.sv
rtl/qtbn_front.sv
rtl/qtbn_queue.sv
rtl/qtbn_divider.sv
rtl/qtangent_to_tbn_matrix_unit.sv
sim/tb_top.sv
